/* sv/integer_to_ascii_formatter_macros.svh */
// Assertion macros shared by the formatter's checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, disabled during reset.
`define ITAF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("formatter check failed");

// Next-cycle implication, clocked on i_clk, disabled during reset.
`define ITAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("formatter check failed");

`endif

/* sv/itaf_pkg.sv */
// Shared types, constants and helpers of the integer to ASCII formatter.
`default_nettype none

package itaf_pkg;

    // Format kinds carried on the input tuser.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_DEC  = 2'd0;
    localparam t_kind KIND_HEX2 = 2'd1;
    localparam t_kind KIND_HEX4 = 2'd2;
    localparam t_kind KIND_HEX8 = 2'd3;

    // Character codes.
    localparam logic [7:0] ASCII_ZERO     = 8'd48;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd55;
    localparam logic [7:0] ASCII_MINUS    = 8'h2D;

    // Divide by ten: q = (x * DEC_RECIP) >> RECIP_SHIFT, exact for 32-bit x.
    localparam logic [31:0] DEC_RECIP   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUO_W       = 64 - RECIP_SHIFT;

    // Digit buffer: up to ten decimal digits or eight hex digits.
    localparam int NUM_NIBS  = 10;
    localparam int NIB_IDX_W = 4;
    typedef logic [NUM_NIBS-1:0][3:0] t_nibs;

    // Last hex digit index of each hex kind.
    localparam logic [NIB_IDX_W-1:0] HEX2_LAST = 4'd1;
    localparam logic [NIB_IDX_W-1:0] HEX4_LAST = 4'd3;
    localparam logic [NIB_IDX_W-1:0] HEX8_LAST = 4'd7;

    // One classified item, ready to print: digits least significant first.
    typedef struct packed {
        logic                 neg;
        logic [NIB_IDX_W-1:0] last_idx;
        t_nibs                nibs;
    } t_entry;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Front and back state machines.
    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_SIGN,
        BE_DIGIT
    } t_be_state;

    // Map one digit value to its uppercase ASCII character.
    function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
        logic [7:0] w_ext;
        w_ext = {4'b0000, nib};
        if (nib < 4'd10) begin
            return w_ext + ASCII_ZERO;
        end
        return w_ext + HEX_ALPHA_BASE;
    endfunction

endpackage

`default_nettype wire

/* sv/itaf_front.sv */
// Front end: accepts items, classifies them and converts decimal magnitudes to digits.
`default_nettype none

module itaf_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire itaf_pkg::t_kind      i_kind,
    input  wire logic signed [31:0]   i_value,
    input  wire itaf_pkg::t_q_status  i_q_status,
    output logic                      o_push,
    output itaf_pkg::t_entry          o_entry
);

    itaf_pkg::t_fe_state r_state, n_state;
    logic [31:0]                    r_cur, n_cur;
    logic [31:0]                    r_prev, n_prev;
    logic                           r_pv, n_pv;
    logic [itaf_pkg::NIB_IDX_W-1:0] r_cnt, n_cnt;
    logic [itaf_pkg::NIB_IDX_W-1:0] r_last_idx, n_last_idx;
    logic                           r_neg, n_neg;
    itaf_pkg::t_nibs                r_nibs, n_nibs;

    logic [31:0]                    w_bits;
    logic [63:0]                    w_prod;
    logic [itaf_pkg::QUO_W-1:0]     w_quo;
    logic [3:0]                     w_digit;

    assign w_bits = i_value;

    // Reciprocal multiply gives the next quotient by ten.
    assign w_prod = r_cur * itaf_pkg::DEC_RECIP;
    assign w_quo  = w_prod[63:itaf_pkg::RECIP_SHIFT];

    // Remainder of the previous value: only the low four bits of prev - 10 * cur matter.
    assign w_digit = r_prev[3:0] - {r_cur[0], 3'b000} - {r_cur[2:0], 1'b0};

    assign o_ready = (r_state == itaf_pkg::FE_IDLE);
    assign o_push  = (r_state == itaf_pkg::FE_PUSH);
    assign o_entry = '{neg: r_neg, last_idx: r_last_idx, nibs: r_nibs};

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itaf_pkg::FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_pv       <= n_pv;
        r_cnt      <= n_cnt;
        r_last_idx <= n_last_idx;
        r_neg      <= n_neg;
        r_nibs     <= n_nibs;
    end

    // Next state: classify on transfer, then one digit per cycle for decimal.
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_pv       = r_pv;
        n_cnt      = r_cnt;
        n_last_idx = r_last_idx;
        n_neg      = r_neg;
        n_nibs     = r_nibs;
        case (r_state)
            itaf_pkg::FE_IDLE: begin
                if (i_valid) begin
                    n_pv   = 1'b0;
                    n_cnt  = '0;
                    n_neg  = 1'b0;
                    n_nibs = {8'h00, w_bits};
                    case (i_kind)
                        itaf_pkg::KIND_DEC: begin
                            n_neg   = w_bits[31];
                            n_cur   = w_bits[31] ? (32'd0 - w_bits) : w_bits;
                            n_state = itaf_pkg::FE_CONV;
                        end
                        itaf_pkg::KIND_HEX2: begin
                            n_last_idx = itaf_pkg::HEX2_LAST;
                            n_state    = itaf_pkg::FE_PUSH;
                        end
                        itaf_pkg::KIND_HEX4: begin
                            n_last_idx = itaf_pkg::HEX4_LAST;
                            n_state    = itaf_pkg::FE_PUSH;
                        end
                        default: begin
                            n_last_idx = itaf_pkg::HEX8_LAST;
                            n_state    = itaf_pkg::FE_PUSH;
                        end
                    endcase
                end
            end
            itaf_pkg::FE_CONV: begin
                n_cur  = 32'(w_quo);
                n_prev = r_cur;
                n_pv   = 1'b1;
                if (r_pv) begin
                    n_nibs[r_cnt] = w_digit;
                    n_cnt         = r_cnt + 1'b1;
                    // The quotient reached zero: this was the leading digit.
                    if (r_cur == 32'd0) begin
                        n_last_idx = r_cnt;
                        n_state    = itaf_pkg::FE_PUSH;
                    end
                end
            end
            itaf_pkg::FE_PUSH: begin
                if (!i_q_status.full) begin
                    n_state = itaf_pkg::FE_IDLE;
                end
            end
            default: begin
                n_state = itaf_pkg::FE_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/itaf_queue.sv */
// Two-entry queue that decouples the front end from the character emitter.
`default_nettype none

module itaf_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire itaf_pkg::t_entry     i_entry,
    input  wire logic                 i_pop,
    output itaf_pkg::t_entry          o_entry,
    output itaf_pkg::t_q_status       o_status
);

    itaf_pkg::t_entry               r_mem [itaf_pkg::QUEUE_DEPTH];
    logic [itaf_pkg::QPTR_W-1:0]    r_wp;
    logic [itaf_pkg::QPTR_W-1:0]    r_rp;
    logic [itaf_pkg::QCNT_W-1:0]    r_cnt;
    logic                           w_do_push;
    logic                           w_do_pop;

    assign o_status.full  = (r_cnt == itaf_pkg::QCNT_W'(itaf_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_entry        = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* sv/itaf_back.sv */
// Back end: emits the characters of one queued item, most significant first.
`default_nettype none

module itaf_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire itaf_pkg::t_entry     i_entry,
    input  wire itaf_pkg::t_q_status  i_q_status,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [7:0]                o_char,
    output logic                      o_last
);

    itaf_pkg::t_be_state            r_state, n_state;
    itaf_pkg::t_entry               r_ent, n_ent;
    logic [itaf_pkg::NIB_IDX_W-1:0] r_idx, n_idx;
    logic                           r_ovalid, n_ovalid;
    logic [7:0]                     r_ochar, n_ochar;
    logic                           r_olast, n_olast;
    logic                           w_load;

    // The output register may take a new character when empty or being drained.
    assign w_load  = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= itaf_pkg::BE_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_idx   <= n_idx;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    // Next state: take an entry, then one character per output transfer slot.
    always_comb begin
        n_state  = r_state;
        n_ent    = r_ent;
        n_idx    = r_idx;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        n_ovalid = r_ovalid && !i_ready;
        o_pop    = 1'b0;
        case (r_state)
            itaf_pkg::BE_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_ent   = i_entry;
                    n_idx   = i_entry.last_idx;
                    n_state = i_entry.neg ? itaf_pkg::BE_SIGN : itaf_pkg::BE_DIGIT;
                end
            end
            itaf_pkg::BE_SIGN: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_ochar  = itaf_pkg::ASCII_MINUS;
                    n_olast  = 1'b0;
                    n_state  = itaf_pkg::BE_DIGIT;
                end
            end
            itaf_pkg::BE_DIGIT: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_ochar  = itaf_pkg::nib_to_ascii(r_ent.nibs[r_idx]);
                    n_olast  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = itaf_pkg::BE_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = itaf_pkg::BE_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter.
`default_nettype none

// Formats a 32-bit two's complement number as ASCII text, one character per
// output transfer, with tlast on the final character. tuser selects the format:
// decimal (a '-' for negative numbers, then the magnitude without leading zeros,
// the most negative number printing as -2147483648), or exactly 2, 4 or 8
// uppercase hex digits of the low bits. A front end takes an item and, for
// decimal, works out one digit per cycle with a divide-by-ten reciprocal
// multiplier; it takes no new item until it has pushed the current one into
// a two-entry queue. The queue feeds the emitter, which fetches an entry and
// then loads its characters one at a time into its output register, holding
// while the receiver stalls. The two sides overlap, so with an always-ready
// receiver a stream of ten-digit decimal numbers is limited by the front end's
// digit conversion, not by the emitter. Nothing needs clearing after reset.
module integer_to_ascii_formatter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic signed [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]         i_s_axis_tuser,   // [1:0] kind
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [7:0]              o_m_axis_tdata,   // [7:0] char_out
    output logic                    o_m_axis_tlast    // last
);

    logic                 w_push;
    logic                 w_pop;
    itaf_pkg::t_entry     w_push_entry;
    itaf_pkg::t_entry     w_head_entry;
    itaf_pkg::t_q_status  w_q_status;

    // Accept and classify items, convert decimal magnitudes.
    itaf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_kind     (i_s_axis_tuser),
        .i_value    (i_s_axis_tdata),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    // Decoupling queue.
    itaf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_head_entry),
        .o_status (w_q_status)
    );

    // Character emitter with its output register.
    itaf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_head_entry),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_char     (o_m_axis_tdata),
        .o_last     (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

/* sv/itaf_checker.sv */
// Port-level checks of the formatter's output stream, bound to the top level.
`default_nettype none

`include "integer_to_ascii_formatter_macros.svh"

module itaf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] i_m_tdata,
    input wire logic       i_m_tlast
);

    logic w_is_minus;
    logic w_is_digit;
    logic w_is_alpha;
    logic w_xfer;

    assign w_is_minus = (i_m_tdata == itaf_pkg::ASCII_MINUS);
    assign w_is_digit = (i_m_tdata >= 8'h30) && (i_m_tdata <= 8'h39);
    assign w_is_alpha = (i_m_tdata >= 8'h41) && (i_m_tdata <= 8'h46);
    assign w_xfer     = i_m_tvalid && i_m_tready;

    // A stalled character holds until it is taken.
    `ITAF_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))

    // Only a sign, a decimal digit or an uppercase hex digit is ever shown.
    `ITAF_ASSERT_NOW(a_char_legal, i_m_tvalid, w_is_minus || w_is_digit || w_is_alpha)

    // A sign never ends a run.
    `ITAF_ASSERT_NOW(a_minus_not_last, i_m_tvalid && w_is_minus, !i_m_tlast)

    // A sign is followed by a nonzero leading digit, never by another sign.
    `ITAF_ASSERT_NEXT(a_minus_then_digit, w_xfer && w_is_minus, !i_m_tvalid || ((i_m_tdata >= 8'h31) && (i_m_tdata <= 8'h39)))

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);

`default_nettype wire

/* test/integer_to_ascii_formatter_checker.sv */
// Checker for the integer to ASCII formatter: predicts each character and compares.
`default_nettype none

module itaf_text_checker
    import itaf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [7:0]  i_m_axis_tdata,   // [7:0] char_out
    input  wire logic        i_m_axis_tlast,
    output int               o_fail_count,
    output int               o_pending
);

    // One predicted character of the output text.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    t_text_char expected_text[$];
    t_text_char head_char;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Character code of one digit value, uppercase for ten and above.
    function automatic logic [7:0] ascii_of_digit(input logic [3:0] digit);
        logic [7:0] wide;
        wide = {4'b0000, digit};
        if (digit < 4'd10) begin
            return ASCII_ZERO + wide;
        end
        return HEX_ALPHA_BASE + wide;
    endfunction

    function automatic void queue_char(input logic [7:0] ch, input logic last);
        t_text_char entry;
        entry.ch   = ch;
        entry.last = last;
        expected_text.push_back(entry);
    endfunction

    // Work out the text that one number and format kind produce.
    function automatic void predict_text(input t_kind kind, input logic [31:0] bits);
        logic [31:0] mag;
        logic [3:0]  digits [10];
        int          n_digits;
        int          n_hex;
        n_digits = 0;
        if (kind == KIND_DEC) begin
            mag = bits;
            // The magnitude is taken in 32 unsigned bits, so the most
            // negative number does not overflow.
            if (bits[31]) begin
                queue_char(ASCII_MINUS, 1'b0);
                mag = -bits;
            end
            do begin
                digits[n_digits] = 4'(mag % 32'd10);
                mag = mag / 32'd10;
                n_digits++;
            end while (mag != 32'd0);
            for (int i = n_digits - 1; i >= 0; i--) begin
                queue_char(ascii_of_digit(digits[i]), i == 0);
            end
        end else begin
            n_hex = (kind == KIND_HEX2) ? 2 : ((kind == KIND_HEX4) ? 4 : 8);
            for (int i = n_hex - 1; i >= 0; i--) begin
                queue_char(ascii_of_digit(bits[i*4 +: 4]), i == 0);
            end
        end
    endfunction

    // Compare each output transfer with the oldest prediction, then predict
    // from the input transfer of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_text.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected character: expected none, got 0x%02h last %0b",
                             $time, i_m_axis_tdata, i_m_axis_tlast);
                end else begin
                    head_char = expected_text.pop_front();
                    if (i_m_axis_tdata !== head_char.ch) begin
                        o_fail_count++;
                        $display("%0t: char mismatch: expected 0x%02h, got 0x%02h",
                                 $time, head_char.ch, i_m_axis_tdata);
                    end
                    if (i_m_axis_tlast !== head_char.last) begin
                        o_fail_count++;
                        $display("%0t: tlast mismatch: expected %0b, got %0b",
                                 $time, head_char.last, i_m_axis_tlast);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_text(i_s_axis_tuser, i_s_axis_tdata);
            end
        end
        o_pending = expected_text.size();
    end

endmodule

`default_nettype wire

/* test/testbench.sv */
// Testbench top for the integer to ASCII formatter: stimulus, flow control and verdict.
`default_nettype none

module testbench;
    import itaf_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int RANDOM_ITEMS  = 320;
    localparam int DRAIN_CYCLES  = 30;
    localparam int HOLD_CYCLES   = 250;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic signed [31:0] i_s_axis_tdata;   // [31:0] value
    logic [1:0]         i_s_axis_tuser;   // [1:0] kind
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [7:0]         o_m_axis_tdata;   // [7:0] char_out
    logic               o_m_axis_tlast;

    int fail_count;
    int pending;
    int cycle_count;
    int tx_steady_left;

    integer_to_ascii_formatter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    itaf_text_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Clock with a period of 4.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Run limit.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random numbers, and numbers aimed at digit-count boundaries, small values and extremes.
    function automatic logic [31:0] pick_value();
        logic [31:0] pow;
        logic [31:0] v;
        int          k;
        k   = $urandom_range(0, 9);
        pow = 32'd1;
        repeat (k) pow = pow * 32'd10;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = pow + $urandom_range(0, 2) - 32'd1;
            2: v = $urandom_range(pow, (k == 9) ? 32'h7FFF_FFFF : pow * 32'd10 - 32'd1);
            3: v = $urandom_range(0, 15);
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h8000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    function automatic t_kind pick_kind();
        case ($urandom_range(0, 7))
            4: return KIND_HEX2;
            5: return KIND_HEX4;
            6, 7: return KIND_HEX8;
            default: return KIND_DEC;
        endcase
    endfunction

    // Offer one number after a random gap and wait for its transfer.
    task automatic send_number(input t_kind kind, input logic [31:0] value);
        int gap;
        if (tx_steady_left > 0) begin
            tx_steady_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 29) == 0) begin
                tx_steady_left = $urandom_range(15, 40);
            end
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted character has come out.
    task automatic wait_until_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, stretches always ready, and two long hold-offs.
    initial begin
        int rx_cycles;
        int stall_left;
        int steady_left;
        int hold_left;
        rx_cycles       = 0;
        stall_left      = 0;
        steady_left     = 0;
        hold_left       = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycles++;
            if (rx_cycles == 1500 || rx_cycles == 4000) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (steady_left > 0) begin
                    steady_left--;
                end else if ($urandom_range(0, 19) == 0) begin
                    steady_left = $urandom_range(30, 80);
                end else begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Sender: reset, directed numbers, then random numbers, then the verdict.
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = KIND_DEC;
        tx_steady_left  = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Decimal corner cases: zero, one digit, sign, digit-count edges and extremes.
        send_number(KIND_DEC, 32'd0);
        send_number(KIND_DEC, 32'd9);
        send_number(KIND_DEC, 32'd10);
        send_number(KIND_DEC, -32'd1);
        send_number(KIND_DEC, -32'd10);
        send_number(KIND_DEC, 32'd999_999_999);
        send_number(KIND_DEC, 32'd1_000_000_000);
        send_number(KIND_DEC, 32'h7FFF_FFFF);
        send_number(KIND_DEC, 32'h8000_0000);
        send_number(KIND_DEC, 32'h8000_0001);
        // Hex widths with all digit values and ignored upper bits.
        send_number(KIND_HEX2, 32'h0000_0000);
        send_number(KIND_HEX2, 32'hFFFF_FFFF);
        send_number(KIND_HEX2, 32'h1234_56A9);
        send_number(KIND_HEX4, 32'h0000_0000);
        send_number(KIND_HEX4, 32'hFFFF_FFFF);
        send_number(KIND_HEX4, 32'hABCD_0F1E);
        send_number(KIND_HEX8, 32'h0000_0000);
        send_number(KIND_HEX8, 32'hFFFF_FFFF);
        send_number(KIND_HEX8, 32'h0123_4567);
        send_number(KIND_HEX8, 32'h89AB_CDEF);
        send_number(KIND_HEX8, 32'h8000_0000);
        wait_until_drained();

        // Random numbers, with one full drain halfway through.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                wait_until_drained();
            end
            send_number(pick_kind(), pick_value());
        end
        i_s_axis_tvalid <= 1'b0;

        // Let the last characters out and watch for stray ones.
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+sv
sv/itaf_pkg.sv
sv/itaf_front.sv
sv/itaf_queue.sv
sv/itaf_back.sv
sv/integer_to_ascii_formatter.sv
sv/itaf_checker.sv
test/integer_to_ascii_formatter_checker.sv
test/testbench.sv
